FILE: hdl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// operation and status codes for the sorted insert list
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam logic [2:0] KIND_INSERT    = 3'd0;
  localparam logic [2:0] KIND_POP_FRONT = 3'd1;
  localparam logic [2:0] KIND_POP_BACK  = 3'd2;
  localparam logic [2:0] KIND_FIND      = 3'd3;
  localparam logic [2:0] KIND_REMOVE    = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_FULL      = 3'd1;
  localparam logic [2:0] STATUS_EMPTY     = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_BAD_POS   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_PUT  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

FILE: hdl/sorted_insert_list.sv
// ----------------------------------------------------------------------------
// sorted_insert_list
// sorted store of up to DEPTH unsigned values in one synchronous memory, with
// stable insert, pop front, pop back, ranged find and remove at a position
//
//   channel  direction  handshake             payload
//   item     in         item_valid/item_stall kind, value, position, end_position
//   result   out        result_valid/result_stall
//                                             result_value, result_position,
//                                             status, entry_count
//   cfg      in         cfg_valid/cfg_ready   cfg_data (order_descending)
//
// one memory read per cycle sets the pace: insert walks back from the tail to
// its slot, pop front and remove walk from the position to the tail, find
// walks its range, and an insert that lands at the front ends with a write
// of slot 0 in ST_PUT; operations that read no entry go from idle straight
// to ST_FIN
// reset clears the count, the order and the result valid flag; the memory is
// not cleared, only entries below the count are read
// a stalled result waits in its register while the next item is taken
// ----------------------------------------------------------------------------
module sorted_insert_list #(
  parameter int DEPTH      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [2:0]                     kind,
  input  logic [VALUE_BITS-1:0]          value,
  input  logic [$clog2(DEPTH+1)-1:0]     position,
  input  logic [$clog2(DEPTH+1)-1:0]     end_position,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [VALUE_BITS-1:0]          result_value,
  output logic [$clog2(DEPTH+1)-1:0]     result_position,
  output logic [2:0]                     status,
  output logic [$clog2(DEPTH+1)-1:0]     entry_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  sil_pkg::state_t       state, state_next;
  logic [2:0]            op, op_next;
  logic [VALUE_BITS-1:0] val, val_next;
  logic [CW-1:0]         pos, pos_next;
  logic [CW-1:0]         endp, endp_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         idx, idx_next;
  logic [VALUE_BITS-1:0] rval, rval_next;
  logic [CW-1:0]         rpos, rpos_next;
  logic [2:0]            st, st_next;
  logic                  ord;

  logic                  item_take;
  logic                  res_load;
  logic                  val_first;
  logic [CW-1:0]         idx_ext;
  logic [CW-1:0]         idx_p1;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != sil_pkg::ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign res_load   = (state == sil_pkg::ST_FIN) && (!result_valid || !result_stall);
  assign idx_ext    = CW'(idx);
  assign idx_p1     = idx_ext + CW'(1);
  // value to insert sorts strictly before the entry just read
  assign val_first  = ord ? (val > rd_data) : (val < rd_data);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    val_next   = val;
    pos_next   = pos;
    endp_next  = endp;
    count_next = count;
    idx_next   = idx;
    rval_next  = rval;
    rpos_next  = rpos;
    st_next    = st;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;

    unique case (state)
      sil_pkg::ST_IDLE: begin
        if (item_take) begin
          op_next    = kind;
          val_next   = value;
          pos_next   = position;
          endp_next  = end_position;
          rval_next  = '0;
          rpos_next  = '0;
          st_next    = sil_pkg::STATUS_OK;
          state_next = sil_pkg::ST_FIN;
          case (kind)
            sil_pkg::KIND_INSERT: begin
              if (count == CW'(DEPTH)) begin
                st_next = sil_pkg::STATUS_FULL;
              end else if (count == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = value;
                count_next = count + CW'(1);
              end else begin
                rd_en      = 1'b1;
                rd_addr    = AW'(count - CW'(1));
                idx_next   = AW'(count - CW'(1));
                state_next = sil_pkg::ST_RUN;
              end
            end
            sil_pkg::KIND_POP_FRONT: begin
              pos_next = '0;
              if (count == '0) begin
                st_next = sil_pkg::STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = sil_pkg::ST_RUN;
              end
            end
            sil_pkg::KIND_POP_BACK: begin
              if (count == '0) begin
                st_next = sil_pkg::STATUS_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = AW'(count - CW'(1));
                idx_next   = AW'(count - CW'(1));
                state_next = sil_pkg::ST_RUN;
              end
            end
            sil_pkg::KIND_FIND: begin
              if (position > end_position || end_position > count) begin
                st_next = sil_pkg::STATUS_BAD_POS;
              end else if (position == end_position) begin
                st_next   = sil_pkg::STATUS_NOT_FOUND;
                rpos_next = end_position;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = position[AW-1:0];
                idx_next   = position[AW-1:0];
                state_next = sil_pkg::ST_RUN;
              end
            end
            sil_pkg::KIND_REMOVE: begin
              if (position >= count) begin
                st_next = sil_pkg::STATUS_BAD_POS;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = position[AW-1:0];
                idx_next   = position[AW-1:0];
                state_next = sil_pkg::ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      sil_pkg::ST_RUN: begin
        case (op)
          sil_pkg::KIND_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_p1);
            if (val_first) begin
              // entry moves one slot toward the tail
              wr_data = rd_data;
              if (idx == '0) begin
                state_next = sil_pkg::ST_PUT;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = idx - AW'(1);
                idx_next = idx - AW'(1);
              end
            end else begin
              wr_data    = val;
              rpos_next  = idx_p1;
              count_next = count + CW'(1);
              state_next = sil_pkg::ST_FIN;
            end
          end
          sil_pkg::KIND_POP_BACK: begin
            rval_next  = rd_data;
            count_next = count - CW'(1);
            state_next = sil_pkg::ST_FIN;
          end
          sil_pkg::KIND_FIND: begin
            if (rd_data == val) begin
              rval_next  = rd_data;
              rpos_next  = idx_ext;
              state_next = sil_pkg::ST_FIN;
            end else if (idx_p1 == endp) begin
              st_next    = sil_pkg::STATUS_NOT_FOUND;
              rpos_next  = endp;
              state_next = sil_pkg::ST_FIN;
            end else begin
              rd_en    = 1'b1;
              rd_addr  = AW'(idx_p1);
              idx_next = AW'(idx_p1);
            end
          end
          default: begin
            // pop front and remove: take the entry, then close the gap
            if (idx_ext == pos) begin
              rval_next = rd_data;
              rpos_next = pos;
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx - AW'(1);
              wr_data = rd_data;
            end
            if (idx_p1 < count) begin
              rd_en    = 1'b1;
              rd_addr  = AW'(idx_p1);
              idx_next = AW'(idx_p1);
            end else begin
              count_next = count - CW'(1);
              state_next = sil_pkg::ST_FIN;
            end
          end
        endcase
      end

      sil_pkg::ST_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = val;
        rpos_next  = '0;
        count_next = count + CW'(1);
        state_next = sil_pkg::ST_FIN;
      end

      sil_pkg::ST_FIN: begin
        if (res_load) begin
          state_next = sil_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sil_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sil_pkg::ST_IDLE;
      count        <= '0;
      ord          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        ord <= cfg_data;
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    val  <= val_next;
    pos  <= pos_next;
    endp <= endp_next;
    idx  <= idx_next;
    rval <= rval_next;
    rpos <= rpos_next;
    st   <= st_next;
    if (res_load) begin
      result_value    <= rval;
      result_position <= rpos;
      status          <= st;
      entry_count     <= count;
    end
  end

endmodule
